FILE: hw/rtl/table_linear_interpolation_defines.svh
// Assertion macros for the checker file of the interpolation block.
`ifndef TABLE_LINEAR_INTERPOLATION_DEFINES_SVH
`define TABLE_LINEAR_INTERPOLATION_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define TLI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define TLI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tli_pkg.sv
`timescale 1ns / 1ps

package tli_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned ALU_W     = 36;
  localparam int unsigned MUL_STEPS = DIFF_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned MIN_ENTRIES = 2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LO    = 14'b00000000000010,
    S_HI    = 14'b00000000000100,
    S_CLAMP = 14'b00000000001000,
    S_SCAN  = 14'b00000000010000,
    S_RDLO  = 14'b00000000100000,
    S_RDHI  = 14'b00000001000000,
    S_DEN   = 14'b00000010000000,
    S_DX    = 14'b00000100000000,
    S_DY    = 14'b00001000000000,
    S_ABS   = 14'b00010000000000,
    S_MUL   = 14'b00100000000000,
    S_DIV   = 14'b01000000000000,
    S_SUM   = 14'b10000000000000
  } state_e;

  // Sign extension of a table word or a difference onto the shared adder.
  function automatic logic [ALU_W-1:0] sext_data(input logic [DATA_W-1:0] v);
    return {{(ALU_W - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] sext_diff(input logic [DIFF_W-1:0] v);
    return {{(ALU_W - DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

endpackage

FILE: hw/rtl/tli_if.sv
`timescale 1ns / 1ps

interface tli_in_if;
  import tli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [IDX_W-1:0]         entry_index;
  logic signed [DATA_W-1:0] entry_x;
  logic signed [DATA_W-1:0] entry_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, mode, entry_index, entry_x, entry_y, query_x,
                  input ready);
  modport sink (input valid, mode, entry_index, entry_x, entry_y, query_x,
                output ready);
endinterface

interface tli_out_if;
  import tli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_y;
  logic [IDX_W-1:0]         segment_index;
  logic                     divide_fault;

  modport source (output valid, result_y, segment_index, divide_fault, input ready);
  modport sink (input valid, result_y, segment_index, divide_fault, output ready);
endinterface

interface tli_cfg_if;
  import tli_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hw/rtl/tli_ram.sv
`timescale 1ns / 1ps

module tli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tli_alu.sv
`timescale 1ns / 1ps

module tli_alu (
  input  logic [tli_pkg::ALU_W-1:0] a_i,
  input  logic [tli_pkg::ALU_W-1:0] b_i,
  input  logic                      sub_i,
  output logic [tli_pkg::ALU_W-1:0] sum_o
);
  import tli_pkg::*;

  // Two's complement add or subtract; the sequencer's data compares read the sign.
  assign sum_o = a_i + (sub_i ? ~b_i : b_i) + ALU_W'(sub_i);

endmodule

FILE: hw/rtl/table_linear_interpolation.sv
`timescale 1ns / 1ps
// A write transaction gives no result. A query runs through the whole sequence below,
// with a scan whose length follows the index of the first breakpoint not below the
// clamped x; on a zero-width segment it skips the multiply and the divide.
// Throughput: one write a cycle while idle; a query holds the input until its result.
// Reset (rst_ni low, asynchronous) idles the sequencer, drops the output and sets
// entries_in_use to 2; the table stores are not cleared and must be written first.
module table_linear_interpolation #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tli_cfg_if.sink   cfg_i,
  tli_in_if.sink    in_i,
  tli_out_if.source out_o
);
  import tli_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  // The sequencer walks one query through these steps, reusing one adder:
  //   read the first and last breakpoints in use and clamp x against them,
  //   scan the breakpoints one per cycle for the first one not below x,
  //   read both ends of the segment and form den, dx and dy with signs,
  //   take magnitudes, shift-add multiply dx by dy (one bit a cycle),
  //   restoring divide by den (one bit a cycle), then add to y_lo and saturate.
  // Every read goes through the registered read port of the two table RAMs,
  // so the data shows up in the cycle after its address is in the address register.

  state_e state_q, state_d;

  logic [CFG_W-1:0]  entries_q;
  logic [AW-1:0]     last_idx;
  logic [31:0]       ent_w;

  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     cmp_idx_q, cmp_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     seg_q, seg_d;
  logic              lo_clamp_q, lo_clamp_d;

  logic [DATA_W-1:0] qx_q, qx_d;
  logic [DATA_W-1:0] x_q, x_d;
  logic [DATA_W-1:0] xlo_q, xlo_d;
  logic [DATA_W-1:0] ylo_q, ylo_d;
  logic [DATA_W-1:0] yhi_q, yhi_d;
  logic [DIFF_W-1:0] den_q, den_d;
  logic [DIFF_W-1:0] dx_q, dx_d;
  logic [DIFF_W-1:0] dy_q, dy_d;
  logic              neg_q, neg_d;
  logic              fault_q, fault_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DIFF_W-1:0] rem_q, rem_d;
  logic [6:0]        cnt_q, cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [IDX_W-1:0]  seg_out_q, seg_out_d;
  logic              fault_out_q, fault_out_d;

  logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_sub;
  logic              alu_neg;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] bp_rdata, val_rdata;

  logic [DIFF_W-1:0] abs_val;
  logic [DIFF_W-1:0] abs_mag;
  logic [DIFF_W:0]   div_rem;
  logic [DIFF_W:0]   quo_cap;

  // Entry count clamped to the range the table supports, kept as the last index.
  always_comb begin
    ent_w = 32'(entries_q);
    if (ent_w > 32'(TABLE_DEPTH)) begin
      last_idx = AW'(TABLE_DEPTH - 1);
    end else if (ent_w < 32'(MIN_ENTRIES)) begin
      last_idx = AW'(1);
    end else begin
      last_idx = AW'(ent_w - 32'd1);
    end
  end

  // Writes land only while idle; positions past the table are dropped.
  assign ram_we    = state_q[0] && in_i.valid && (in_i.mode == MODE_WRITE) &&
                     (32'(in_i.entry_index) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_i.entry_index);

  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.entry_x),
    .raddr_i (addr_q),
    .rdata_o (bp_rdata)
  );

  tli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.entry_y),
    .raddr_i (addr_q),
    .rdata_o (val_rdata)
  );

  tli_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum)
  );

  assign alu_neg = alu_sum[ALU_W-1];

  // The magnitude step works through den, dx and dy in that order.
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    abs_val = den_q;
      2'd1:    abs_val = dx_q;
      default: abs_val = dy_q;
    endcase
    abs_mag = abs_val[DIFF_W-1] ? alu_sum[DIFF_W-1:0] : abs_val;
  end

  assign div_rem = {rem_q, prod_q[PROD_W-1]};

  // Any quotient at or past 2^33 saturates the result, so it is capped there.
  assign quo_cap = (|prod_q[PROD_W-1:DIFF_W]) ? {1'b1, {DIFF_W{1'b0}}}
                                              : {1'b0, prod_q[DIFF_W-1:0]};

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = cmp_vld_q;
    seg_d       = seg_q;
    lo_clamp_d  = lo_clamp_q;
    qx_d        = qx_q;
    x_d         = x_q;
    xlo_d       = xlo_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    den_d       = den_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    neg_d       = neg_q;
    fault_d     = fault_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    seg_out_d   = seg_out_q;
    fault_out_d = fault_out_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b1;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid && (in_i.mode == MODE_QUERY)) begin
          qx_d    = in_i.query_x;
          addr_d  = '0;
          state_d = S_LO;
        end
      end
      S_LO: begin
        addr_d  = last_idx;
        state_d = S_HI;
      end
      S_HI: begin
        // The first breakpoint is on the read port: clamp x from below.
        alu_a      = sext_data(bp_rdata);
        alu_b      = sext_data(qx_q);
        lo_clamp_d = !alu_neg;
        x_d        = alu_neg ? qx_q : bp_rdata;
        state_d    = S_CLAMP;
      end
      S_CLAMP: begin
        // The last breakpoint in use is on the read port: clamp from above.
        alu_a = sext_data(qx_q);
        alu_b = sext_data(bp_rdata);
        if (!lo_clamp_q && !alu_neg) begin
          x_d = bp_rdata;
        end
        addr_d    = '0;
        cmp_vld_d = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        alu_a = sext_data(bp_rdata);
        alu_b = sext_data(x_q);
        priority if (cmp_vld_q && !alu_neg) begin
          seg_d   = (cmp_idx_q == '0) ? AW'(1) : cmp_idx_q;
          addr_d  = seg_d - AW'(1);
          state_d = S_RDLO;
        end else if (cmp_vld_q && (cmp_idx_q == last_idx)) begin
          // No breakpoint reached x, which only an unordered table allows.
          seg_d   = AW'(1);
          addr_d  = '0;
          state_d = S_RDLO;
        end else begin
          cmp_idx_d = addr_q;
          cmp_vld_d = 1'b1;
          addr_d    = addr_q + AW'(1);
        end
      end
      S_RDLO: begin
        addr_d  = seg_q;
        state_d = S_RDHI;
      end
      S_RDHI: begin
        xlo_d   = bp_rdata;
        ylo_d   = val_rdata;
        state_d = S_DEN;
      end
      S_DEN: begin
        alu_a = sext_data(bp_rdata);
        alu_b = sext_data(xlo_q);
        yhi_d = val_rdata;
        den_d = alu_sum[DIFF_W-1:0];
        if (alu_sum[DIFF_W-1:0] == '0) begin
          // Zero-width segment: a zero quotient leaves the lower y as the result.
          fault_d = 1'b1;
          prod_d  = '0;
          neg_d   = 1'b0;
          state_d = S_SUM;
        end else begin
          fault_d = 1'b0;
          state_d = S_DX;
        end
      end
      S_DX: begin
        alu_a   = sext_data(x_q);
        alu_b   = sext_data(xlo_q);
        dx_d    = alu_sum[DIFF_W-1:0];
        state_d = S_DY;
      end
      S_DY: begin
        alu_a   = sext_data(yhi_q);
        alu_b   = sext_data(ylo_q);
        dy_d    = alu_sum[DIFF_W-1:0];
        neg_d   = den_q[DIFF_W-1] ^ dx_q[DIFF_W-1] ^ alu_sum[DIFF_W-1];
        cnt_d   = '0;
        state_d = S_ABS;
      end
      S_ABS: begin
        alu_a = '0;
        alu_b = sext_diff(abs_val);
        unique case (cnt_q[1:0])
          2'd0:    den_d = abs_mag;
          2'd1:    dx_d  = abs_mag;
          default: dy_d  = abs_mag;
        endcase
        if (cnt_q == 7'd2) begin
          prod_d  = {{DIFF_W{1'b0}}, abs_mag};
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_MUL: begin
        // Shift-add: add dx to the upper half when the low multiplier bit is set.
        alu_sub = 1'b0;
        alu_a   = ALU_W'(prod_q[PROD_W-1:DIFF_W]);
        alu_b   = prod_q[0] ? ALU_W'(dx_q) : '0;
        prod_d  = {alu_sum[DIFF_W:0], prod_q[DIFF_W-1:1]};
        if (cnt_q == 7'(MUL_STEPS - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_DIV: begin
        // Restoring division: the quotient bits shift in behind the dividend.
        alu_a  = ALU_W'(div_rem);
        alu_b  = ALU_W'(den_q);
        rem_d  = alu_neg ? div_rem[DIFF_W-1:0] : alu_sum[DIFF_W-1:0];
        prod_d = {prod_q[PROD_W-2:0], !alu_neg};
        if (cnt_q == 7'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = S_SUM;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_SUM: begin
        alu_sub = neg_q;
        alu_a   = sext_data(ylo_q);
        alu_b   = ALU_W'(quo_cap);
        if (!out_valid_q || out_o.ready) begin
          if (&alu_sum[ALU_W-1:DATA_W-1] || !(|alu_sum[ALU_W-1:DATA_W-1])) begin
            res_d = alu_sum[DATA_W-1:0];
          end else if (alu_neg) begin
            res_d = {1'b1, {(DATA_W - 1){1'b0}}};
          end else begin
            res_d = {1'b0, {(DATA_W - 1){1'b1}}};
          end
          seg_out_d   = IDX_W'(seg_q);
          fault_out_d = fault_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= CFG_W'(MIN_ENTRIES);
      cmp_vld_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_vld_q   <= cmp_vld_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        entries_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    cmp_idx_q   <= cmp_idx_d;
    seg_q       <= seg_d;
    lo_clamp_q  <= lo_clamp_d;
    qx_q        <= qx_d;
    x_q         <= x_d;
    xlo_q       <= xlo_d;
    ylo_q       <= ylo_d;
    yhi_q       <= yhi_d;
    den_q       <= den_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    neg_q       <= neg_d;
    fault_q     <= fault_d;
    prod_q      <= prod_d;
    rem_q       <= rem_d;
    res_q       <= res_d;
    seg_out_q   <= seg_out_d;
    fault_out_q <= fault_out_d;
  end

  // Always ready; the user must write only while the block is idle, which is unchecked.
  assign cfg_i.ready = 1'b1;

  assign in_i.ready = state_q[0];

  assign out_o.valid         = out_valid_q;
  assign out_o.result_y      = signed'(res_q);
  assign out_o.segment_index = seg_out_q;
  assign out_o.divide_fault  = fault_out_q;

endmodule

FILE: hw/rtl/tli_checker.sv
`timescale 1ns / 1ps
`include "table_linear_interpolation_defines.svh"

module tli_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_mode_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tli_pkg::DATA_W-1:0]  result_y_i,
  input logic [tli_pkg::IDX_W-1:0]   segment_index_i,
  input logic                        divide_fault_i
);
  import tli_pkg::*;

  // A waiting result keeps its payload until it is taken.
  `TLI_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(result_y_i) && $stable(segment_index_i) && $stable(divide_fault_i), "result changed while stalled")

  // A query occupies the block, so no second transaction follows directly.
  `TLI_ASSERT_NXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_i && (in_mode_i == MODE_QUERY), !in_ready_i, "input ready right after a query")

  // A table write never produces a result.
  `TLI_ASSERT_NXT(a_write_silent, clk_i, rst_ni, in_valid_i && in_ready_i && (in_mode_i == MODE_WRITE) && !out_valid_i, !out_valid_i, "result after a table write")

  // A new result only comes out of a busy cycle.
  `TLI_ASSERT_IMP(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "result appeared while idle")

endmodule

bind table_linear_interpolation tli_checker u_tli_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_mode_i       (in_i.mode),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .result_y_i      (out_o.result_y),
  .segment_index_i (out_o.segment_index),
  .divide_fault_i  (out_o.divide_fault)
);
